### src/rfgbs_pkg.sv
// ----------------------------------------------------------------------------
// rfgbs_pkg: shared types and constants
// Mode codes, pixel and command types and divider reciprocals for the RGB
// flip / gray / box smoothing streamer.
// ----------------------------------------------------------------------------
package rfgbs_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [1:0] {
		MODE_FLIP   = 2'd0,
		MODE_GRAY   = 2'd1,
		MODE_SMOOTH = 2'd2
	} mode_t;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	// floor(x/3) for x < 768 and floor(x/9) for x < 2304
	localparam logic [11:0] GRAY_RECIP   = 12'd2731;
	localparam int          GRAY_SHIFT   = 13;
	localparam logic [12:0] SMOOTH_RECIP = 13'd7282;
	localparam int          SMOOTH_SHIFT = 16;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	// one step for the back end
	typedef struct packed {
		mode_t mode;
		logic  emit;     // produces a result
		logic  last;     // final result of the frame
		logic  wr;       // real pixel, written to the line store
		logic  row_par;  // parity of the current row
		logic  top_ok;   // row two above is in frame
		logic  mid_ok;   // row above is in frame
		logic  bot_ok;   // current row is in frame
		logic  edge0;    // first column: right neighbour column is out of frame
		logic  left_ok;  // left neighbour column is in frame
		pix_t  pix;
	} cmd_t;

endpackage

### src/rgb_flip_gray_box_smooth.sv
// ----------------------------------------------------------------------------
// rgb_flip_gray_box_smooth: RGB frame streamer
// Pixels in raster order on s_axis, results on m_axis, registers on cfg_*.
//
// Registers: 0 mode (0 mirror rows, 1 gray average, 2 or 3 3x3 box smooth),
// 1 frame width (0 counts as 1, clamped to MAX_WIDTH), 2 frame height.
// Any write to a listed register restarts the frame.
// s_axis_tuser = 1 is a drain tick: after the last pixel of a frame, each
// tick returns one of the results still owed (a row for mirror, a row plus
// one pixel for smoothing). m_axis_tlast marks the frame's final result.
// Throughput is one item per clock unless m_axis stalls or an internal step
// runs; the line store is two single-port-read RAMs of MAX_WIDTH pixels, one
// per row parity. In a one-row smoothing frame the first drain tick adds an
// internal drain step. A stalled m_axis fills the four-entry command queue,
// after which s_axis_tready drops. Reset returns to mode 0, 1x1 frame; line
// store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module rgb_flip_gray_box_smooth #(
	parameter int MAX_WIDTH = rfgbs_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // blue, green, red from MSB down
	input  logic        s_axis_tuser,   // op: drain tick
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // blue, green, red from MSB down
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $bits(rfgbs_pkg::cmd_t);
	localparam int QW = CW + 2 * AW;

	logic            push;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	rfgbs_pkg::cmd_t push_cmd;
	logic [AW-1:0]   push_wr_addr;
	logic [AW-1:0]   push_rd_addr;
	logic [QW-1:0]   hd_data;
	rfgbs_pkg::pix_t out_pix;

	assign cfg_ready = 1'b1;

	rfgbs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser),
		.in_pix       (rfgbs_pkg::pix_t'(s_axis_tdata)),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd),
		.push_wr_addr (push_wr_addr),
		.push_rd_addr (push_rd_addr)
	);

	rfgbs_fifo #(.WIDTH(QW), .DEPTH(rfgbs_pkg::QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_wr_addr, push_rd_addr, push_cmd}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (hd_data),
		.empty     (q_empty)
	);

	rfgbs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.hd_cmd     (rfgbs_pkg::cmd_t'(hd_data[CW-1:0])),
		.hd_wr_addr (hd_data[QW-1 -: AW]),
		.hd_rd_addr (hd_data[CW +: AW]),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pix    (out_pix),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = out_pix;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command queue underflow");

	a_pixel_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tuser && !cfg_valid) |-> push)
		else $error("accepted pixel produced no command");

endmodule

### src/rfgbs_ram.sv
// ----------------------------------------------------------------------------
// rfgbs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module rfgbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/rfgbs_fifo.sv
// ----------------------------------------------------------------------------
// rfgbs_fifo: command queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module rfgbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rfgbs_pkg::QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = data_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wp_q] <= push_data;
		end
	end

endmodule

### src/rfgbs_front.sv
// ----------------------------------------------------------------------------
// rfgbs_front: input classifier
// Holds the configuration, tracks the raster position and the drain state,
// and turns each pixel, and each drain tick while draining, into a command.
// ----------------------------------------------------------------------------
module rfgbs_front #(
	parameter int MAX_WIDTH = rfgbs_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_op,
	input  rfgbs_pkg::pix_t      in_pix,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 q_full,
	output logic                 push,
	output rfgbs_pkg::cmd_t      push_cmd,
	output logic [AW-1:0]        push_wr_addr,
	output logic [AW-1:0]        push_rd_addr
);

	logic [1:0]       mode_q;
	logic [10:0]      fw_q;
	logic [15:0]      fh_q;
	logic [AW-1:0]    col_q;
	logic [15:0]      row_q;
	logic [AW-1:0]    vcol_q;
	logic             vsec_q;
	logic             drain_q;
	logic             extra_q;

	logic [AW-1:0]    wm1;
	logic [15:0]      hm1;
	rfgbs_pkg::mode_t emode;
	logic             acc;
	logic             pix_step;
	logic             drn_step;
	logic             frame_end;
	rfgbs_pkg::cmd_t  pcmd;
	rfgbs_pkg::cmd_t  vcmd;
	logic [AW-1:0]    prd;
	logic [AW-1:0]    vrd;

	always_comb begin
		if (fw_q == '0) begin
			wm1 = '0;
		end else if (32'(fw_q) > MAX_WIDTH) begin
			wm1 = AW'(MAX_WIDTH - 1);
		end else begin
			wm1 = AW'(fw_q - 11'd1);
		end
		hm1 = (fh_q == '0) ? '0 : fh_q - 16'd1;
		if (mode_q[1]) begin
			emode = rfgbs_pkg::MODE_SMOOTH;
		end else if (mode_q[0]) begin
			emode = rfgbs_pkg::MODE_GRAY;
		end else begin
			emode = rfgbs_pkg::MODE_FLIP;
		end
	end

	assign in_ready  = !q_full && !extra_q;
	assign acc       = in_valid && in_ready;
	assign pix_step  = acc && !in_op;
	assign drn_step  = (acc && in_op && drain_q) || (extra_q && !q_full);
	assign frame_end = (col_q == wm1) && (row_q == hm1);

	// pixel command
	always_comb begin
		pcmd         = '0;
		pcmd.mode    = emode;
		pcmd.wr      = 1'b1;
		pcmd.row_par = row_q[0];
		pcmd.top_ok  = (row_q[15:1] != '0);
		pcmd.mid_ok  = (row_q != '0);
		pcmd.bot_ok  = 1'b1;
		pcmd.edge0   = (col_q == '0);
		pcmd.left_ok = (col_q == '0) ? (wm1 != '0) : (col_q[AW-1:1] != '0);
		pcmd.pix     = in_pix;
		prd          = col_q;
		unique case (emode)
			rfgbs_pkg::MODE_FLIP: begin
				pcmd.emit = (row_q != '0);
				prd       = wm1 - col_q;
			end
			rfgbs_pkg::MODE_GRAY: begin
				pcmd.emit = 1'b1;
				pcmd.last = frame_end;
			end
			rfgbs_pkg::MODE_SMOOTH: begin
				pcmd.emit = (row_q[15:1] != '0) || ((row_q == 16'd1) && (col_q != '0));
			end
			default: begin
				pcmd.emit = 1'b0;
			end
		endcase
	end

	// drain command: positions past the end of the frame
	always_comb begin
		vcmd         = '0;
		vcmd.mode    = emode;
		vcmd.row_par = ~hm1[0];
		vcmd.top_ok  = (hm1 != '0);
		vcmd.mid_ok  = 1'b1;
		vcmd.edge0   = (vcol_q == '0);
		vcmd.left_ok = (vcol_q == '0) ? (wm1 != '0) : (vcol_q[AW-1:1] != '0);
		vrd          = vcol_q;
		if (emode == rfgbs_pkg::MODE_SMOOTH) begin
			if (vsec_q) begin
				vcmd.emit    = 1'b1;
				vcmd.last    = 1'b1;
				vcmd.edge0   = 1'b1;
				vcmd.left_ok = (wm1 != '0);
			end else begin
				vcmd.emit = !((hm1 == '0) && (vcol_q == '0));
			end
		end else begin
			vcmd.emit = 1'b1;
			vcmd.last = (vcol_q == wm1);
			vrd       = wm1 - vcol_q;
		end
	end

	assign push         = pix_step || drn_step;
	assign push_cmd     = pix_step ? pcmd : vcmd;
	assign push_wr_addr = col_q;
	assign push_rd_addr = pix_step ? prd : vrd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 2'd0;
			fw_q    <= 11'd1;
			fh_q    <= 16'd1;
			col_q   <= '0;
			row_q   <= '0;
			vcol_q  <= '0;
			vsec_q  <= 1'b0;
			drain_q <= 1'b0;
			extra_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfgbs_pkg::CFG_MODE:   mode_q <= cfg_data[1:0];
				rfgbs_pkg::CFG_WIDTH:  fw_q   <= cfg_data[10:0];
				rfgbs_pkg::CFG_HEIGHT: fh_q   <= cfg_data;
				default: ;
			endcase
			if (cfg_index <= rfgbs_pkg::CFG_HEIGHT) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= 1'b0;
				extra_q <= 1'b0;
			end
		end else if (pix_step) begin
			drain_q <= 1'b0;
			if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				vcol_q  <= '0;
				vsec_q  <= 1'b0;
				drain_q <= (emode != rfgbs_pkg::MODE_GRAY);
			end else if (col_q == wm1) begin
				col_q <= '0;
				row_q <= row_q + 16'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end else if (drn_step) begin
			extra_q <= !vcmd.emit;
			if (vcmd.emit && vcmd.last) begin
				drain_q <= 1'b0;
			end
			if ((emode == rfgbs_pkg::MODE_SMOOTH) && !vsec_q && (vcol_q == wm1)) begin
				vsec_q <= 1'b1;
				vcol_q <= '0;
			end else begin
				vcol_q <= vcol_q + AW'(1);
			end
		end
	end

endmodule

### src/rfgbs_back.sv
// ----------------------------------------------------------------------------
// rfgbs_back: execution pipeline
// Line store access, window column sums, divide by reciprocal, output register.
// ----------------------------------------------------------------------------
module rfgbs_back #(
	parameter int MAX_WIDTH = rfgbs_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  rfgbs_pkg::cmd_t hd_cmd,
	input  logic [AW-1:0]   hd_wr_addr,
	input  logic [AW-1:0]   hd_rd_addr,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output rfgbs_pkg::pix_t out_pix,
	output logic            out_last
);

	logic                   adv;
	logic [1:0][23:0]       rq;
	logic                   v_s1;
	rfgbs_pkg::cmd_t        cmd_s1;
	logic                   v_s2;
	logic                   last_s2;
	rfgbs_pkg::mode_t       mode_s2;
	logic [2:0][11:0]       num_s2;
	logic [2:0][9:0]        lft_q;
	logic [2:0][9:0]        ctr_q;
	logic [2:0][7:0]        top_w;
	logic [2:0][7:0]        mid_w;
	logic [2:0][7:0]        cur_w;
	logic [2:0][9:0]        tri_w;
	logic [2:0][11:0]       num_w;
	logic [11:0]            gsum;
	logic [2:0][7:0]        res_w;
	logic [2:0][23:0]       gprod;
	logic [2:0][24:0]       sprod;

	assign adv = !out_valid || out_ready;
	assign pop = adv && !q_empty;

	for (genvar p = 0; p < 2; p++) begin : g_line
		rfgbs_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram (
			.clk   (clk),
			.we    (pop && hd_cmd.wr && (hd_cmd.row_par == 1'(p))),
			.waddr (hd_wr_addr),
			.wdata (hd_cmd.pix),
			.re    (adv),
			.raddr (hd_rd_addr),
			.rdata (rq[p])
		);
	end

	always_comb begin
		top_w = cmd_s1.row_par ? rq[1] : rq[0];
		mid_w = cmd_s1.row_par ? rq[0] : rq[1];
		cur_w = cmd_s1.pix;
		gsum  = 12'(cur_w[0]) + 12'(cur_w[1]) + 12'(cur_w[2]);
		for (int c = 0; c < 3; c++) begin
			tri_w[c] = (cmd_s1.top_ok ? 10'(top_w[c]) : 10'd0)
			         + (cmd_s1.mid_ok ? 10'(mid_w[c]) : 10'd0)
			         + (cmd_s1.bot_ok ? 10'(cur_w[c]) : 10'd0);
			unique case (cmd_s1.mode)
				rfgbs_pkg::MODE_FLIP:   num_w[c] = 12'(mid_w[c]);
				rfgbs_pkg::MODE_GRAY:   num_w[c] = gsum;
				rfgbs_pkg::MODE_SMOOTH: num_w[c] = (cmd_s1.left_ok ? 12'(lft_q[c]) : 12'd0)
				                                 + 12'(ctr_q[c])
				                                 + (cmd_s1.edge0 ? 12'd0 : 12'(tri_w[c]));
				default:                num_w[c] = '0;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			gprod[c] = 24'(num_s2[c][9:0]) * 24'(rfgbs_pkg::GRAY_RECIP);
			sprod[c] = 25'(num_s2[c]) * 25'(rfgbs_pkg::SMOOTH_RECIP);
			unique case (mode_s2)
				rfgbs_pkg::MODE_FLIP:   res_w[c] = num_s2[c][7:0];
				rfgbs_pkg::MODE_GRAY:
					res_w[c] = gprod[c][rfgbs_pkg::GRAY_SHIFT +: 8];
				rfgbs_pkg::MODE_SMOOTH:
					res_w[c] = sprod[c][rfgbs_pkg::SMOOTH_SHIFT +: 8];
				default:                res_w[c] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= pop;
			v_s2      <= v_s1 && cmd_s1.emit;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= hd_cmd;
			last_s2  <= cmd_s1.last;
			mode_s2  <= cmd_s1.mode;
			num_s2   <= num_w;
			out_last <= last_s2;
			out_pix  <= rfgbs_pkg::pix_t'(res_w);
			if (v_s1 && (cmd_s1.mode == rfgbs_pkg::MODE_SMOOTH)) begin
				lft_q <= ctr_q;
				ctr_q <= tri_w;
			end
		end
	end

endmodule
